@@ hw/rtl/look_at_view_matrix_defines.svh @@
// ----------------------------------------------------------------------------
// Look-at view matrix: assertion macros
// Shared concurrent assertion forms, clocked on clk_i and off during reset.
// ----------------------------------------------------------------------------
`ifndef LOOK_AT_VIEW_MATRIX_DEFINES_SVH
`define LOOK_AT_VIEW_MATRIX_DEFINES_SVH

// same-cycle implication
`define LAV_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("look_at_view_matrix: assertion failed");

// next-cycle implication
`define LAV_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("look_at_view_matrix: assertion failed");

`endif

@@ hw/rtl/lav_pkg.sv @@
// ----------------------------------------------------------------------------
// lav_pkg
// Shared widths, row codes, result row type and rounding helper.
// ----------------------------------------------------------------------------
package lav_pkg;

  localparam int unsigned SQRT_STEPS  = 26;              // root bits
  localparam int unsigned RAD_W       = 2 * SQRT_STEPS;  // radicand bits
  localparam int unsigned ROOT_W      = SQRT_STEPS;
  localparam int unsigned QUO_W       = 17;              // quotient <= 2^16
  localparam int unsigned NUM_W       = 42;
  localparam int unsigned DEN_W       = ROOT_W;
  localparam int unsigned ITEM_CYCLES = 3;
  localparam int unsigned BUSY_W      = 2;
  // accept register .. final row register
  localparam int unsigned PIPE_LAT    = 3 + 2 * (SQRT_STEPS + 1 + QUO_W) + 7 + 6;

  typedef logic [1:0] row_idx_t;
  localparam row_idx_t ROW_SIDE = 2'd0;
  localparam row_idx_t ROW_UP   = 2'd1;
  localparam row_idx_t ROW_FWD  = 2'd2;

  typedef struct packed {
    row_idx_t           row_index;
    logic signed [31:0] col_0;
    logic signed [31:0] col_1;
    logic signed [31:0] col_2;
    logic signed [31:0] col_3;
    logic               degenerate;
    logic               last_row;
  } row_t;

  // arithmetic shift right by k, rounding half away from zero
  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] x,
                                                input int unsigned k);
    logic [63:0] m;
    m = x[63] ? 64'(-x) : 64'(x);
    m = (m + (64'd1 << (k - 1))) >> k;
    return x[63] ? -$signed(m) : $signed(m);
  endfunction

endpackage

@@ hw/rtl/lav_sqrt.sv @@
// ----------------------------------------------------------------------------
// lav_sqrt
// Pipelined digit-by-digit integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module lav_sqrt (
  input  logic                        clk_i,
  input  logic [lav_pkg::RAD_W-1:0]   rad_i,
  output logic [lav_pkg::ROOT_W-1:0]  root_o
);
  import lav_pkg::*;

  localparam int unsigned REM_W = ROOT_W + 3;

  logic [RAD_W-1:0]  rad_q  [SQRT_STEPS];
  logic [REM_W-1:0]  rem_q  [SQRT_STEPS];
  logic [ROOT_W-1:0] root_q [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    logic [RAD_W-1:0]  rad_in;
    logic [REM_W-1:0]  rem_in;
    logic [REM_W-1:0]  rem2;
    logic [REM_W-1:0]  trial;
    logic [ROOT_W-1:0] root_in;
    logic              ge;

    if (k == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    // bring down the next two radicand bits, try root*4+1
    assign rem2  = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
    assign trial = REM_W'({root_in, 2'b01});
    assign ge    = (rem2 >= trial);

    always_ff @(posedge clk_i) begin
      rad_q[k]  <= rad_in << 2;
      rem_q[k]  <= ge ? (rem2 - trial) : rem2;
      root_q[k] <= {root_in[ROOT_W-2:0], ge};
    end
  end

  assign root_o = root_q[SQRT_STEPS-1];

endmodule

@@ hw/rtl/lav_div.sv @@
// ----------------------------------------------------------------------------
// lav_div
// Pipelined restoring divider, one quotient bit per stage. The upper
// numerator bits must already be below the divisor.
// ----------------------------------------------------------------------------
module lav_div (
  input  logic                       clk_i,
  input  logic [lav_pkg::NUM_W-1:0]  num_i,
  input  logic [lav_pkg::DEN_W-1:0]  den_i,
  output logic [lav_pkg::QUO_W-1:0]  quo_o
);
  import lav_pkg::*;

  logic [DEN_W-1:0] rem_q [QUO_W];
  logic [QUO_W-1:0] low_q [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    logic [DEN_W-1:0] rem_in;
    logic [QUO_W-1:0] low_in;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;
    logic [DEN_W:0]   rem2;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in = DEN_W'(num_i[NUM_W-1:QUO_W]);
      assign low_in = num_i[QUO_W-1:0];
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign low_in = low_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign rem2 = {rem_in, low_in[QUO_W-1]};
    assign ge   = (rem2 >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      rem_q[k] <= ge ? DEN_W'(rem2 - {1'b0, den_in}) : DEN_W'(rem2);
      low_q[k] <= low_in << 1;
      den_q[k] <= den_in;
      quo_q[k] <= {quo_in[QUO_W-2:0], ge};
    end
  end

  assign quo_o = quo_q[QUO_W-1];

endmodule

@@ hw/rtl/look_at_view_matrix.sv @@
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Fixed-point camera look-at matrix: three rows (side, up, negated forward)
// with saturated translation terms, from eye, target and up hint.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive the nine Q8.8 coordinates with start high; the word is
//   taken at a clock edge where start is high and busy is low. busy stays
//   high after each accepted word until the busy counter runs out.
//   Output: every input word gives three rows on strobe_o, one per cycle
//   on consecutive cycles, row_index 0, 1, 2, last_row on the third.
//   Input words are spaced by busy, set by the single row port that
//   carries three rows per word. The datapath itself is a fixed 104-stage
//   pipeline: two 26-stage square roots and two banks of three 17-stage
//   dividers, one bit per stage.
//   Reset: rst_ni clears busy, all valid bits and the output strobe; words
//   in flight are dropped.
//   The receiver cannot stall; each row is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module look_at_view_matrix (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic signed [15:0] eye_x_i,
  input  logic signed [15:0] eye_y_i,
  input  logic signed [15:0] eye_z_i,
  input  logic signed [15:0] target_x_i,
  input  logic signed [15:0] target_y_i,
  input  logic signed [15:0] target_z_i,
  input  logic signed [15:0] upward_x_i,
  input  logic signed [15:0] upward_y_i,
  input  logic signed [15:0] upward_z_i,
  output logic               busy,
  output logic               strobe_o,
  output logic [1:0]         row_index_o,
  output logic signed [31:0] col_0_o,
  output logic signed [31:0] col_1_o,
  output logic signed [31:0] col_2_o,
  output logic signed [31:0] col_3_o,
  output logic               degenerate_o,
  output logic               last_row_o
);
  import lav_pkg::*;

  typedef struct packed {
    logic [2:0][15:0] eye;
    logic [2:0][16:0] d;
    logic [2:0][15:0] up;
    logic             deg;
  } side_a_t;

  typedef struct packed {
    logic [2:0][15:0] eye;
    logic [2:0][15:0] up;
    logic [2:0]       sgn;
    logic             deg;
  } side_b_t;

  typedef struct packed {
    logic [2:0][25:0] r;
    logic [2:0][17:0] n;
    logic [2:0][15:0] eye;
    logic             deg;
  } side_c_t;

  typedef struct packed {
    logic [2:0][17:0] n;
    logic [2:0][15:0] eye;
    logic [2:0]       sgn;
    logic             deg;
  } side_d_t;

  // ---------------- handshake and valid line ----------------
  logic                accept;
  logic [BUSY_W-1:0]   busy_cnt_q;
  logic [PIPE_LAT-1:0] vld_q;

  assign accept = start && !busy;
  assign busy   = (busy_cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_cnt_q <= '0;
      vld_q      <= '0;
    end else begin
      vld_q <= {vld_q[PIPE_LAT-2:0], accept};
      if (accept) begin
        busy_cnt_q <= BUSY_W'(ITEM_CYCLES - 1);
      end else if (busy_cnt_q != '0) begin
        busy_cnt_q <= busy_cnt_q - 1'b1;
      end
    end
  end

  // ---------------- forward axis: d, |d|^2 ----------------
  logic signed [15:0] eye0_q [3];
  logic signed [15:0] up0_q  [3];
  logic signed [16:0] d0_q   [3];

  always_ff @(posedge clk_i) begin
    eye0_q[0] <= eye_x_i;
    eye0_q[1] <= eye_y_i;
    eye0_q[2] <= eye_z_i;
    up0_q[0]  <= upward_x_i;
    up0_q[1]  <= upward_y_i;
    up0_q[2]  <= upward_z_i;
    d0_q[0]   <= 17'(target_x_i) - 17'(eye_x_i);
    d0_q[1]   <= 17'(target_y_i) - 17'(eye_y_i);
    d0_q[2]   <= 17'(target_z_i) - 17'(eye_z_i);
  end

  logic signed [33:0] dsq1_q [3];
  logic signed [15:0] eye1_q [3];
  logic signed [15:0] up1_q  [3];
  logic signed [16:0] d1_q   [3];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      dsq1_q[i] <= d0_q[i] * d0_q[i];
      eye1_q[i] <= eye0_q[i];
      up1_q[i]  <= up0_q[i];
      d1_q[i]   <= d0_q[i];
    end
  end

  logic [33:0]      s2;
  logic [RAD_W-1:0] rad2_q;
  side_a_t          sa2_q;

  assign s2 = 34'(dsq1_q[0]) + 34'(dsq1_q[1]) + 34'(dsq1_q[2]);

  always_ff @(posedge clk_i) begin
    rad2_q    <= RAD_W'({s2, 16'd0});
    sa2_q.deg <= (s2 == '0);
    for (int i = 0; i < 3; i++) begin
      sa2_q.eye[i] <= eye1_q[i];
      sa2_q.d[i]   <= d1_q[i];
      sa2_q.up[i]  <= up1_q[i];
    end
  end

  logic [ROOT_W-1:0] len_fwd;
  side_a_t           sa_q [SQRT_STEPS];

  lav_sqrt u_sqrt_fwd (
    .clk_i  (clk_i),
    .rad_i  (rad2_q),
    .root_o (len_fwd)
  );

  always_ff @(posedge clk_i) begin
    sa_q[0] <= sa2_q;
    for (int j = 1; j < SQRT_STEPS; j++) sa_q[j] <= sa_q[j-1];
  end

  // ---------------- n = d / |d| ----------------
  logic [NUM_W-1:0] num3_q [3];
  logic [DEN_W-1:0] den3_q;
  side_b_t          sb3_q;
  logic [16:0]      dmag3 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dmag3[i] = sa_q[SQRT_STEPS-1].d[i][16] ? 17'(-sa_q[SQRT_STEPS-1].d[i])
                                              : sa_q[SQRT_STEPS-1].d[i];
    end
  end

  always_ff @(posedge clk_i) begin
    den3_q    <= len_fwd;
    sb3_q.deg <= sa_q[SQRT_STEPS-1].deg;
    for (int i = 0; i < 3; i++) begin
      num3_q[i]    <= NUM_W'({dmag3[i][15:0], 24'd0}) + NUM_W'(len_fwd[ROOT_W-1:1]);
      sb3_q.sgn[i] <= sa_q[SQRT_STEPS-1].d[i][16];
      sb3_q.eye[i] <= sa_q[SQRT_STEPS-1].eye[i];
      sb3_q.up[i]  <= sa_q[SQRT_STEPS-1].up[i];
    end
  end

  logic [QUO_W-1:0] qn [3];
  side_b_t          sb_q [QUO_W];

  for (genvar i = 0; i < 3; i++) begin : g_div_n
    lav_div u_div (
      .clk_i (clk_i),
      .num_i (num3_q[i]),
      .den_i (den3_q),
      .quo_o (qn[i])
    );
  end

  always_ff @(posedge clk_i) begin
    sb_q[0] <= sb3_q;
    for (int j = 1; j < QUO_W; j++) sb_q[j] <= sb_q[j-1];
  end

  logic signed [17:0] n4_q   [3];
  logic signed [15:0] eye4_q [3];
  logic signed [15:0] up4_q  [3];
  logic               deg4_q;

  always_ff @(posedge clk_i) begin
    deg4_q <= sb_q[QUO_W-1].deg;
    for (int i = 0; i < 3; i++) begin
      n4_q[i]   <= sb_q[QUO_W-1].sgn[i] ? -$signed(18'(qn[i])) : $signed(18'(qn[i]));
      eye4_q[i] <= $signed(sb_q[QUO_W-1].eye[i]);
      up4_q[i]  <= $signed(sb_q[QUO_W-1].up[i]);
    end
  end

  // ---------------- Gram-Schmidt residual r ----------------
  logic signed [33:0] pu5_q  [3];
  logic signed [17:0] n5_q   [3];
  logic signed [15:0] eye5_q [3];
  logic signed [15:0] up5_q  [3];
  logic               deg5_q;

  always_ff @(posedge clk_i) begin
    deg5_q <= deg4_q;
    for (int i = 0; i < 3; i++) begin
      pu5_q[i]  <= up4_q[i] * n4_q[i];
      n5_q[i]   <= n4_q[i];
      eye5_q[i] <= eye4_q[i];
      up5_q[i]  <= up4_q[i];
    end
  end

  logic signed [35:0] a6;
  logic signed [27:0] a16_6_q;
  logic signed [17:0] n6_q   [3];
  logic signed [15:0] eye6_q [3];
  logic signed [15:0] up6_q  [3];
  logic               deg6_q;

  assign a6 = 36'(pu5_q[0]) + 36'(pu5_q[1]) + 36'(pu5_q[2]);

  always_ff @(posedge clk_i) begin
    a16_6_q <= 28'(rnd_shr(64'(a6), 8));
    deg6_q  <= deg5_q;
    for (int i = 0; i < 3; i++) begin
      n6_q[i]   <= n5_q[i];
      eye6_q[i] <= eye5_q[i];
      up6_q[i]  <= up5_q[i];
    end
  end

  logic signed [45:0] pa7_q  [3];
  logic signed [17:0] n7_q   [3];
  logic signed [15:0] eye7_q [3];
  logic signed [15:0] up7_q  [3];
  logic               deg7_q;

  always_ff @(posedge clk_i) begin
    deg7_q <= deg6_q;
    for (int i = 0; i < 3; i++) begin
      pa7_q[i]  <= a16_6_q * n6_q[i];
      n7_q[i]   <= n6_q[i];
      eye7_q[i] <= eye6_q[i];
      up7_q[i]  <= up6_q[i];
    end
  end

  logic signed [25:0] r8_q   [3];
  logic signed [17:0] n8_q   [3];
  logic signed [15:0] eye8_q [3];
  logic               deg8_q;

  always_ff @(posedge clk_i) begin
    deg8_q <= deg7_q;
    for (int i = 0; i < 3; i++) begin
      r8_q[i]   <= 26'(rnd_shr((64'(up7_q[i]) <<< 24) - 64'(pa7_q[i]), 16));
      n8_q[i]   <= n7_q[i];
      eye8_q[i] <= eye7_q[i];
    end
  end

  logic signed [51:0] rsq9_q [3];
  logic signed [25:0] r9_q   [3];
  logic signed [17:0] n9_q   [3];
  logic signed [15:0] eye9_q [3];
  logic               deg9_q;

  always_ff @(posedge clk_i) begin
    deg9_q <= deg8_q;
    for (int i = 0; i < 3; i++) begin
      rsq9_q[i] <= r8_q[i] * r8_q[i];
      r9_q[i]   <= r8_q[i];
      n9_q[i]   <= n8_q[i];
      eye9_q[i] <= eye8_q[i];
    end
  end

  logic [RAD_W-1:0] sv10;
  logic [RAD_W-1:0] rad10_q;
  side_c_t          sc10_q;

  assign sv10 = RAD_W'(rsq9_q[0]) + RAD_W'(rsq9_q[1]) + RAD_W'(rsq9_q[2]);

  always_ff @(posedge clk_i) begin
    rad10_q    <= sv10;
    sc10_q.deg <= deg9_q || (sv10 == '0);
    for (int i = 0; i < 3; i++) begin
      sc10_q.r[i]   <= r9_q[i];
      sc10_q.n[i]   <= n9_q[i];
      sc10_q.eye[i] <= eye9_q[i];
    end
  end

  logic [ROOT_W-1:0] len_up;
  side_c_t           sc_q [SQRT_STEPS];

  lav_sqrt u_sqrt_up (
    .clk_i  (clk_i),
    .rad_i  (rad10_q),
    .root_o (len_up)
  );

  always_ff @(posedge clk_i) begin
    sc_q[0] <= sc10_q;
    for (int j = 1; j < SQRT_STEPS; j++) sc_q[j] <= sc_q[j-1];
  end

  // ---------------- v = r / |r| ----------------
  logic [NUM_W-1:0] num11_q [3];
  logic [DEN_W-1:0] den11_q;
  side_d_t          sd11_q;
  logic [25:0]      rmag11 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rmag11[i] = sc_q[SQRT_STEPS-1].r[i][25] ? 26'(-sc_q[SQRT_STEPS-1].r[i])
                                               : sc_q[SQRT_STEPS-1].r[i];
    end
  end

  always_ff @(posedge clk_i) begin
    den11_q    <= len_up;
    sd11_q.deg <= sc_q[SQRT_STEPS-1].deg;
    for (int i = 0; i < 3; i++) begin
      num11_q[i]    <= NUM_W'({rmag11[i], 16'd0}) + NUM_W'(len_up[ROOT_W-1:1]);
      sd11_q.sgn[i] <= sc_q[SQRT_STEPS-1].r[i][25];
      sd11_q.n[i]   <= sc_q[SQRT_STEPS-1].n[i];
      sd11_q.eye[i] <= sc_q[SQRT_STEPS-1].eye[i];
    end
  end

  logic [QUO_W-1:0] qv [3];
  side_d_t          sd_q [QUO_W];

  for (genvar i = 0; i < 3; i++) begin : g_div_v
    lav_div u_div (
      .clk_i (clk_i),
      .num_i (num11_q[i]),
      .den_i (den11_q),
      .quo_o (qv[i])
    );
  end

  always_ff @(posedge clk_i) begin
    sd_q[0] <= sd11_q;
    for (int j = 1; j < QUO_W; j++) sd_q[j] <= sd_q[j-1];
  end

  logic signed [17:0] v12_q   [3];
  logic signed [17:0] n12_q   [3];
  logic signed [15:0] eye12_q [3];
  logic               deg12_q;

  always_ff @(posedge clk_i) begin
    deg12_q <= sd_q[QUO_W-1].deg;
    for (int i = 0; i < 3; i++) begin
      v12_q[i]   <= sd_q[QUO_W-1].sgn[i] ? -$signed(18'(qv[i])) : $signed(18'(qv[i]));
      n12_q[i]   <= $signed(sd_q[QUO_W-1].n[i]);
      eye12_q[i] <= $signed(sd_q[QUO_W-1].eye[i]);
    end
  end

  // ---------------- w = n x v ----------------
  logic signed [35:0] cp13_q  [6];
  logic signed [17:0] v13_q   [3];
  logic signed [17:0] n13_q   [3];
  logic signed [15:0] eye13_q [3];
  logic               deg13_q;

  always_ff @(posedge clk_i) begin
    cp13_q[0] <= n12_q[1] * v12_q[2];
    cp13_q[1] <= n12_q[2] * v12_q[1];
    cp13_q[2] <= n12_q[2] * v12_q[0];
    cp13_q[3] <= n12_q[0] * v12_q[2];
    cp13_q[4] <= n12_q[0] * v12_q[1];
    cp13_q[5] <= n12_q[1] * v12_q[0];
    deg13_q   <= deg12_q;
    for (int i = 0; i < 3; i++) begin
      v13_q[i]   <= v12_q[i];
      n13_q[i]   <= n12_q[i];
      eye13_q[i] <= eye12_q[i];
    end
  end

  // rows: side w, up v, negated forward
  logic signed [19:0] rows14_q [3][3];
  logic signed [15:0] eye14_q  [3];
  logic               deg14_q;

  always_ff @(posedge clk_i) begin
    deg14_q <= deg13_q;
    for (int i = 0; i < 3; i++) begin
      rows14_q[ROW_SIDE][i] <= 20'(rnd_shr(64'(cp13_q[2*i]) - 64'(cp13_q[2*i+1]), 16));
      rows14_q[ROW_UP][i]   <= 20'(v13_q[i]);
      rows14_q[ROW_FWD][i]  <= -20'(n13_q[i]);
      eye14_q[i]            <= eye13_q[i];
    end
  end

  // ---------------- translation column ----------------
  logic signed [35:0] dp15_q   [3][3];
  logic signed [19:0] rows15_q [3][3];
  logic               deg15_q;

  always_ff @(posedge clk_i) begin
    deg15_q <= deg14_q;
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        dp15_q[k][i]   <= rows14_q[k][i] * eye14_q[i];
        rows15_q[k][i] <= rows14_q[k][i];
      end
    end
  end

  logic signed [37:0] ds16_q   [3];
  logic signed [19:0] rows16_q [3][3];
  logic               deg16_q;

  always_ff @(posedge clk_i) begin
    deg16_q <= deg15_q;
    for (int k = 0; k < 3; k++) begin
      ds16_q[k] <= 38'(dp15_q[k][0]) + 38'(dp15_q[k][1]) + 38'(dp15_q[k][2]);
      for (int i = 0; i < 3; i++) rows16_q[k][i] <= rows15_q[k][i];
    end
  end

  logic signed [63:0] tr17 [3];
  logic signed [31:0] ts17 [3];
  row_t               res17_q [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      tr17[k] = -rnd_shr(64'(ds16_q[k]), 8);
      if (tr17[k] > 64'sd2147483647) begin
        ts17[k] = 32'sh7fff_ffff;
      end else if (tr17[k] < -64'sd2147483648) begin
        ts17[k] = 32'sh8000_0000;
      end else begin
        ts17[k] = 32'(tr17[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      res17_q[k].row_index  <= row_idx_t'(k);
      res17_q[k].col_0      <= deg16_q ? '0 : 32'(rows16_q[k][0]);
      res17_q[k].col_1      <= deg16_q ? '0 : 32'(rows16_q[k][1]);
      res17_q[k].col_2      <= deg16_q ? '0 : 32'(rows16_q[k][2]);
      res17_q[k].col_3      <= deg16_q ? '0 : ts17[k];
      res17_q[k].degenerate <= deg16_q;
      res17_q[k].last_row   <= (row_idx_t'(k) == ROW_FWD);
    end
  end

  // ---------------- row serializer ----------------
  // words arrive no closer than busy allows, so the hold never overflows
  row_t        out_q;
  row_t        hold_q [2];
  logic [1:0]  left_q;
  logic        strobe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
      left_q   <= '0;
    end else if (vld_q[PIPE_LAT-1]) begin
      strobe_q <= 1'b1;
      left_q   <= 2'd2;
    end else if (left_q != '0) begin
      strobe_q <= 1'b1;
      left_q   <= left_q - 1'b1;
    end else begin
      strobe_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_q[PIPE_LAT-1]) begin
      out_q     <= res17_q[ROW_SIDE];
      hold_q[0] <= res17_q[ROW_UP];
      hold_q[1] <= res17_q[ROW_FWD];
    end else if (left_q != '0) begin
      out_q     <= hold_q[0];
      hold_q[0] <= hold_q[1];
    end
  end

  assign strobe_o     = strobe_q;
  assign row_index_o  = out_q.row_index;
  assign col_0_o      = out_q.col_0;
  assign col_1_o      = out_q.col_1;
  assign col_2_o      = out_q.col_2;
  assign col_3_o      = out_q.col_3;
  assign degenerate_o = out_q.degenerate;
  assign last_row_o   = out_q.last_row;

endmodule

@@ hw/rtl/lav_check.sv @@
// ----------------------------------------------------------------------------
// lav_check
// Port-level checks for the look-at matrix block, bound to the top level.
// ----------------------------------------------------------------------------
`include "look_at_view_matrix_defines.svh"

module lav_check (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               strobe_o,
  input logic [1:0]         row_index_o,
  input logic signed [31:0] col_0_o,
  input logic signed [31:0] col_1_o,
  input logic signed [31:0] col_2_o,
  input logic signed [31:0] col_3_o,
  input logic               degenerate_o,
  input logic               last_row_o
);
  import lav_pkg::*;

  // a taken word blocks the next one
  `LAV_ASSERT_NXT(a_busy_after_take, start && !busy, busy)

  // rows of one word come back to back in order
  `LAV_ASSERT_NXT(a_row_order, strobe_o && (row_index_o != ROW_FWD), strobe_o && (row_index_o == $past(row_index_o) + 2'd1))

  `LAV_ASSERT_IMP(a_last_row, strobe_o, last_row_o == (row_index_o == ROW_FWD))

  `LAV_ASSERT_IMP(a_degen_zero, strobe_o && degenerate_o, (col_0_o == '0) && (col_1_o == '0) && (col_2_o == '0) && (col_3_o == '0))

endmodule

bind look_at_view_matrix lav_check u_lav_check (.*);
